// ===== src/sha256_stream_hasher_macros.svh =====
// assertion macros for the sha256 stream hasher
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// property that must hold whenever reset is not asserted
`define SHS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the following cycle
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/shs_pkg.sv =====
//------------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the sha256 stream hasher.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package shs_pkg;

  localparam int unsigned QDepth = 4;

  // request passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } shs_req_t;

  localparam logic [31:0] K_ROM [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] cap0(input logic [31:0] x);
    cap0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] cap1(input logic [31:0] x);
    cap1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ===== src/shs_queue.sv =====
//------------------------------------------------------------------------------
// shs_queue
// Short request queue between the accepting front and the hashing back.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module shs_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire shs_pkg::shs_req_t push_req_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  empty_o,
  output shs_pkg::shs_req_t     pop_req_o
);
  import shs_pkg::*;
  `include "sha256_stream_hasher_macros.svh"

  localparam int unsigned PtrW = $clog2(QDepth);

  shs_req_t        mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o    = (cnt_q == PtrW'(0) + (PtrW+1)'(QDepth));
  assign empty_o   = (cnt_q == '0);
  assign pop_req_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_q] <= push_req_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wr_q <= wr_q + 1'b1;
      if (pop_i && !empty_o) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i && !full_o) - (PtrW+1)'(pop_i && !empty_o);
    end
  end

  `SHS_ASSERT(a_cnt_range, cnt_q <= (PtrW+1)'(QDepth), "queue count overflow")
  `SHS_ASSERT_NEXT(a_push_cnt, push_i && !full_o && !(pop_i && !empty_o),
    cnt_q == $past(cnt_q) + 1'b1, "push did not raise count")
  `SHS_ASSERT_NEXT(a_pop_cnt, pop_i && !empty_o && !(push_i && !full_o),
    cnt_q == $past(cnt_q) - 1'b1, "pop did not lower count")

endmodule
`default_nettype wire

// ===== src/shs_core.sv =====
//------------------------------------------------------------------------------
// shs_core
// Back part: block fill, padding, 64-round compression and digest output.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module shs_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire shs_pkg::shs_req_t req_i,
  output logic                   req_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [31:0]            digest_word_o,
  output logic [2:0]             word_index_o,
  output logic                   last_word_o
);
  import shs_pkg::*;
  `include "sha256_stream_hasher_macros.svh"

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOAD  = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_FOLD  = 6'b001000,
    ST_PAD   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e          state_d, state_q;
  // block held as 16 big-endian words, byte lane 3 is the first byte
  logic [3:0][7:0] buf_q [16];
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic [31:0] h_q [8];
  logic [31:0] w_q [16];
  logic [31:0] r_q [8];
  logic [5:0]  rnd_q;
  logic [3:0]  ld_q;
  logic        final_q;   // current block is the last one of the message
  logic        padded_q;  // 0x80 already placed
  logic        eom_pend_q; // message ended with the byte that filled the block
  logic [2:0]  oidx_q;

  // buffer write port
  logic        bwe;
  logic [5:0]  baddr;
  logic [7:0]  bdata;
  logic [63:0] bit_len;

  // round datapath
  logic [31:0] wt, t1, t2, wnew;

  assign bit_len = {len_q, 3'b000};
  assign wnew = sig1(w_q[14]) + w_q[9] + sig0(w_q[1]) + w_q[0];
  assign wt   = w_q[0];
  assign t1   = r_q[7] + cap1(r_q[4]) + ((r_q[4] & r_q[5]) ^ (~r_q[4] & r_q[6]))
              + K_ROM[rnd_q] + wt;
  assign t2   = cap0(r_q[0]) + ((r_q[0] & r_q[1]) ^ (r_q[0] & r_q[2]) ^ (r_q[1] & r_q[2]));

  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  // control
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    len_d     = len_q;
    req_pop_o = 1'b0;
    bwe       = 1'b0;
    baddr     = fill_q;
    bdata     = req_i.data_byte;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_i.has_byte) begin
            bwe    = 1'b1;
            fill_d = fill_q + 1'b1;
            len_d  = len_q + 1'b1;
            if (fill_q == 6'd63) state_d = ST_LOAD;
            else if (req_i.end_of_message) state_d = ST_PAD;
          end else if (req_i.end_of_message) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // one byte of padding per cycle
        bwe    = 1'b1;
        fill_d = fill_q + 1'b1;
        if (!padded_q) begin
          bdata = PAD_BYTE;
        end else if (fill_q >= LEN_POS && final_q) begin
          bdata = bit_len[6'(63 - 8*int'(fill_q - LEN_POS)) -: 8];
        end else begin
          bdata = 8'h00;
        end
        if (fill_q == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD:  if (ld_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_FOLD;
      ST_FOLD: begin
        if (final_q)                       state_d = ST_OUT;
        else if (padded_q || eom_pend_q)   state_d = ST_PAD;
        else                               state_d = ST_IDLE;
      end
      ST_OUT: begin
        if (!out_stall_i && oidx_q == 3'd7) begin
          state_d = ST_IDLE;
          len_d   = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (bwe) buf_q[baddr[5:2]][2'd3 - baddr[1:0]] <= bdata;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= buf_q[ld_q];
      for (int i = 0; i < 8; i++) r_q[i] <= h_q[i];
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
      r_q[7] <= r_q[6];
      r_q[6] <= r_q[5];
      r_q[5] <= r_q[4];
      r_q[4] <= r_q[3] + t1;
      r_q[3] <= r_q[2];
      r_q[2] <= r_q[1];
      r_q[1] <= r_q[0];
      r_q[0] <= t1 + t2;
    end
  end

  // control registers and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      len_q      <= '0;
      rnd_q      <= '0;
      ld_q       <= '0;
      final_q    <= 1'b0;
      padded_q   <= 1'b0;
      eom_pend_q <= 1'b0;
      oidx_q     <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      if (state_q == ST_IDLE && req_valid_i && req_i.end_of_message) padded_q <= 1'b0;
      // end of message together with the 64th byte, pad after this block
      if (state_q == ST_IDLE && req_valid_i && req_i.has_byte && req_i.end_of_message &&
          fill_q == 6'd63) eom_pend_q <= 1'b1;
      if (state_q == ST_FOLD) eom_pend_q <= 1'b0;
      if (state_q == ST_PAD) begin
        if (!padded_q) begin
          padded_q <= 1'b1;
          // the length fits if the pad byte lands before the length field
          final_q  <= (fill_q < LEN_POS);
        end else if (fill_q == 6'd63) begin
          final_q  <= final_q;
        end
      end
      if (state_q == ST_FOLD && padded_q && !final_q) final_q <= 1'b1;
      ld_q  <= (state_q == ST_LOAD) ? ld_q + 1'b1 : '0;
      rnd_q <= (state_q == ST_ROUND) ? rnd_q + 1'b1 : '0;
      if (state_q == ST_FOLD) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + r_q[i];
      end
      if (state_q == ST_OUT && !out_stall_i) begin
        oidx_q <= oidx_q + 1'b1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
          final_q  <= 1'b0;
          padded_q <= 1'b0;
        end
      end
    end
  end

  // the pop and the output never coincide
  `SHS_ASSERT(a_pop_idle, !req_pop_o || state_q == ST_IDLE, "pop outside idle")
  `SHS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && word_index_o == $past(word_index_o), "stalled output changed")
  `SHS_ASSERT_NEXT(a_fold_after_rounds, state_q == ST_ROUND && rnd_q == 6'd63,
    state_q == ST_FOLD, "rounds did not end in fold")

endmodule
`default_nettype wire

// ===== src/sha256_stream_hasher.sv =====
// SHA-256 over a byte stream. Each request carries at most one byte and may end the message;
// the eight digest words follow the end, word 7 flagged. Requests enter a four-entry queue and
// are held off while it is full. The back end takes one byte per cycle while idle; each full
// 64-byte block then takes 16 word loads, 64 rounds and one fold, all on the one shared
// round unit. Padding writes one byte per cycle up to the block end, so a message ends with
// up to 72 padding bytes, one or two blocks and the eight output words.
//------------------------------------------------------------------------------
// sha256_stream_hasher
// Top level: request queue in front of the hashing back end.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import shs_pkg::*;

  shs_req_t in_req, q_req;
  logic     q_full, q_empty, q_pop;

  assign in_req = '{data_byte: data_byte_i, has_byte: has_byte_i,
                    end_of_message: end_of_message_i};
  assign in_stall_o = q_full;

  // front: request queue
  shs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .push_req_i(in_req), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .pop_req_o(q_req)
  );

  // back: hashing
  shs_core u_core (
    .clk_i, .rst_ni,
    .req_valid_i(!q_empty), .req_i(q_req), .req_pop_o(q_pop),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

endmodule
`default_nettype wire
